/* design/neural_activation_unit_top_assert.svh */
// Assertion macros shared by the activation unit RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef NEURAL_ACTIVATION_UNIT_TOP_ASSERT_SVH
`define NEURAL_ACTIVATION_UNIT_TOP_ASSERT_SVH
`ifndef SYNTH
`define NAU_ASSERT_IMP(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);
`define NAU_ASSERT_NXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);
`else
`define NAU_ASSERT_IMP(label, cond, cons, msg)
`define NAU_ASSERT_NXT(label, cond, cons, msg)
`endif
`endif

/* design/nau_pkg.sv */
// Shared types, constants and constant functions of the activation unit.
// No dependencies.
`default_nettype none
package nau_pkg;
	localparam int PREC = 32;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF = 12;

	typedef enum logic [1:0] {
		ACT_SIGMOID  = 2'd0,
		ACT_TANH     = 2'd1,
		ACT_RELU     = 2'd2,
		ACT_SOFTPLUS = 2'd3
	} act_kind_t;

	typedef struct packed {
		act_kind_t kind;
		logic      neg;
	} side_t;

	localparam logic [PREC:0] ONE = {1'b1, {PREC{1'b0}}};

	// e^(+-2^j) in Q1.PREC, built by squaring e^(+-2^-40) at 124 fraction bits.
	function automatic logic [PREC:0] exp_pow2(input int j, input logic neg);
		logic [127:0] c;
		logic [255:0] prod;
		int i;
		c = 128'd1 << 124;
		if (neg) begin
			c = c - (128'd1 << 84) + (128'd1 << 43);
		end else begin
			c = c + (128'd1 << 84) + (128'd1 << 43);
		end
		for (i = 0; i < 40 + j; i++) begin
			prod = c * c;
			c = prod[124 +: 128];
		end
		return c[124 - PREC +: PREC + 1];
	endfunction
endpackage
`default_nettype wire

/* design/nau_exp.sv */
// Exponential pipeline: e^-t as a product of one constant per set bit of t.
// Depends on nau_pkg.
`default_nettype none
module nau_exp #(
	parameter int DW = 16,
	parameter int FB = 12,
	parameter int TW = 17
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire nau_pkg::side_t          in_side,
	input  wire logic [DW-1:0]           in_x,
	input  wire logic [TW-1:0]           in_t,
	output logic                         out_valid,
	output nau_pkg::side_t               out_side,
	output logic [DW-1:0]                out_x,
	output logic [nau_pkg::PREC:0]       out_e
);
	import nau_pkg::*;

	logic            v_s  [0:TW];
	side_t           sd_s [0:TW];
	logic [DW-1:0]   x_s  [0:TW];
	logic [TW-1:0]   t_s  [0:TW];
	logic [PREC:0]   e_s  [0:TW];

	assign v_s[0]  = in_valid;
	assign sd_s[0] = in_side;
	assign x_s[0]  = in_x;
	assign t_s[0]  = in_t;
	assign e_s[0]  = ONE;

	for (genvar k = 0; k < TW; k++) begin : g_stage
		localparam logic [PREC:0] FACT = exp_pow2(k - FB, 1'b1);
		logic [2*PREC+1:0] prod;
		assign prod = e_s[k] * (t_s[k][k] ? FACT : ONE);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[k+1] <= sd_s[k];
				x_s[k+1]  <= x_s[k];
				t_s[k+1]  <= t_s[k];
				e_s[k+1]  <= prod[PREC +: PREC + 1];
			end
		end
	end

	assign out_valid = v_s[TW];
	assign out_side  = sd_s[TW];
	assign out_x     = x_s[TW];
	assign out_e     = e_s[TW];
endmodule
`default_nettype wire

/* design/nau_div.sv */
// Restoring divider pipeline, one quotient bit per stage, for sigmoid and tanh.
// Depends on nau_pkg.
`default_nettype none
module nau_div #(
	parameter int DW = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire nau_pkg::side_t          in_side,
	input  wire logic [DW-1:0]           in_x,
	input  wire logic [nau_pkg::PREC:0]  in_e,
	output logic                         out_valid,
	output nau_pkg::side_t               out_side,
	output logic [DW-1:0]                out_x,
	output logic [nau_pkg::PREC:0]       out_e,
	output logic [nau_pkg::PREC:0]       out_q
);
	import nau_pkg::*;

	localparam int NS = PREC + 1;

	logic            v_s  [0:NS];
	side_t           sd_s [0:NS];
	logic [DW-1:0]   x_s  [0:NS];
	logic [PREC:0]   e_s  [0:NS];
	logic [PREC+2:0] r_s  [0:NS];
	logic [PREC+1:0] d_s  [0:NS];
	logic [PREC:0]   q_s  [0:NS];

	logic [PREC:0] num;

	always_comb begin
		if (in_side.kind == ACT_TANH) begin
			num = ONE - in_e;
		end else if (in_side.neg) begin
			num = in_e;
		end else begin
			num = ONE;
		end
	end

	assign v_s[0]  = in_valid;
	assign sd_s[0] = in_side;
	assign x_s[0]  = in_x;
	assign e_s[0]  = in_e;
	assign r_s[0]  = {2'b00, num};
	assign d_s[0]  = {1'b0, ONE} + {1'b0, in_e};
	assign q_s[0]  = '0;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [PREC+2:0] r_sh;
		logic            ge;
		assign r_sh = (k == 0) ? r_s[k] : {r_s[k][PREC+1:0], 1'b0};
		assign ge   = r_sh >= {1'b0, d_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[k+1] <= sd_s[k];
				x_s[k+1]  <= x_s[k];
				e_s[k+1]  <= e_s[k];
				d_s[k+1]  <= d_s[k];
				r_s[k+1]  <= ge ? (r_sh - {1'b0, d_s[k]}) : r_sh;
				q_s[k+1]  <= {q_s[k][PREC-1:0], ge};
			end
		end
	end

	assign out_valid = v_s[NS];
	assign out_side  = sd_s[NS];
	assign out_x     = x_s[NS];
	assign out_e     = e_s[NS];
	assign out_q     = q_s[NS];
endmodule
`default_nettype wire

/* design/nau_ln.sv */
// Logarithm pipeline: ln(1+e) by one exponential digit per stage, for softplus.
// Depends on nau_pkg.
`default_nettype none
module nau_ln #(
	parameter int DW = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire nau_pkg::side_t          in_side,
	input  wire logic [DW-1:0]           in_x,
	input  wire logic [nau_pkg::PREC:0]  in_e,
	input  wire logic [nau_pkg::PREC:0]  in_q,
	output logic                         out_valid,
	output nau_pkg::side_t               out_side,
	output logic [DW-1:0]                out_x,
	output logic [nau_pkg::PREC:0]       out_q,
	output logic [nau_pkg::PREC:0]       out_l
);
	import nau_pkg::*;

	logic            v_s  [0:PREC];
	side_t           sd_s [0:PREC];
	logic [DW-1:0]   x_s  [0:PREC];
	logic [PREC:0]   q_s  [0:PREC];
	logic [PREC+1:0] u_s  [0:PREC];
	logic [PREC:0]   w_s  [0:PREC];
	logic [PREC:0]   l_s  [0:PREC];

	assign v_s[0]  = in_valid;
	assign sd_s[0] = in_side;
	assign x_s[0]  = in_x;
	assign q_s[0]  = in_q;
	assign u_s[0]  = {1'b0, ONE} + {1'b0, in_e};
	assign w_s[0]  = ONE;
	assign l_s[0]  = '0;

	for (genvar k = 0; k < PREC; k++) begin : g_stage
		localparam logic [PREC:0] FACT = exp_pow2(-(k + 1), 1'b0);
		localparam logic [PREC:0] DIGIT = ONE >> (k + 1);
		logic [2*PREC+1:0] prod;
		logic [PREC+1:0]   trial;
		logic              take;
		assign prod  = w_s[k] * FACT;
		assign trial = prod[PREC +: PREC + 2];
		assign take  = trial <= u_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[k+1] <= sd_s[k];
				x_s[k+1]  <= x_s[k];
				q_s[k+1]  <= q_s[k];
				u_s[k+1]  <= u_s[k];
				w_s[k+1]  <= take ? trial[PREC:0] : w_s[k];
				l_s[k+1]  <= take ? (l_s[k] | DIGIT) : l_s[k];
			end
		end
	end

	assign out_valid = v_s[PREC];
	assign out_side  = sd_s[PREC];
	assign out_x     = x_s[PREC];
	assign out_q     = q_s[PREC];
	assign out_l     = l_s[PREC];
endmodule
`default_nettype wire

/* design/neural_activation_unit_top.sv */
// Activation unit top level: sigmoid, tanh, ReLU or softplus on a stream.
// The pipeline is an input register, one stage per bit of the argument t in the
// exponential, PREC+1 divider stages, PREC logarithm stages and the output
// register. Throughput is one transfer per cycle; the whole pipeline holds
// while the output waits. Reset clears all valid bits and returns act_kind
// to sigmoid.
`default_nettype none
module neural_activation_unit_top #(
	parameter int DATA_WIDTH = nau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = nau_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [1:0]                          cfg_wdata,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// Fields from bit 0: x_in, then zero fill.
	input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// Fields from bit 0: y_out, then zero fill.
	output logic [((DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
	// Fields from bit 0: clipped.
	output logic                                     m_axis_tuser
);
	import nau_pkg::*;

	localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int TW  = DATA_WIDTH + 1;
	localparam int SH  = PREC - FRAC_BITS;
	localparam int YW  = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 2;
	localparam logic [PREC+1:0] HALF = (PREC + 2)'(1) << (SH - 1);
	localparam logic signed [YW-1:0] YMAX = (YW)'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam logic signed [YW-1:0] YMIN = -YMAX - (YW)'(1);

	// The whole pipeline advances together unless a result waits at the output.
	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	act_kind_t kind_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= ACT_SIGMOID;
		end else if (cfg_we) begin
			kind_q <= act_kind_t'(cfg_wdata);
		end
	end

	// Input register stage.
	logic                  v_s1;
	side_t                 sd_s1;
	logic [DATA_WIDTH-1:0] x_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1       <= s_axis_tdata[DATA_WIDTH-1:0];
			sd_s1.kind <= kind_q;
			sd_s1.neg  <= s_axis_tdata[DATA_WIDTH-1];
		end
	end

	// Magnitude of the argument of e^-t; tanh works on twice |x|.
	logic [DATA_WIDTH-1:0] ax;
	logic [TW-1:0]         t_arg;
	assign ax    = sd_s1.neg ? (~x_s1 + 1'b1) : x_s1;
	assign t_arg = (sd_s1.kind == ACT_TANH) ? {ax, 1'b0} : {1'b0, ax};

	logic                  ev;
	side_t                 esd;
	logic [DATA_WIDTH-1:0] ex;
	logic [PREC:0]         ee;
	nau_exp #(.DW(DATA_WIDTH), .FB(FRAC_BITS), .TW(TW)) u_exp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_side(sd_s1), .in_x(x_s1), .in_t(t_arg),
		.out_valid(ev), .out_side(esd), .out_x(ex), .out_e(ee)
	);

	logic                  dv;
	side_t                 dsd;
	logic [DATA_WIDTH-1:0] dx;
	logic [PREC:0]         de;
	logic [PREC:0]         dq;
	nau_div #(.DW(DATA_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(ev), .in_side(esd), .in_x(ex), .in_e(ee),
		.out_valid(dv), .out_side(dsd), .out_x(dx), .out_e(de), .out_q(dq)
	);

	logic                  lv;
	side_t                 lsd;
	logic [DATA_WIDTH-1:0] lx;
	logic [PREC:0]         lq;
	logic [PREC:0]         ll;
	nau_ln #(.DW(DATA_WIDTH)) u_ln (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(dv), .in_side(dsd), .in_x(dx), .in_e(de), .in_q(dq),
		.out_valid(lv), .out_side(lsd), .out_x(lx), .out_q(lq), .out_l(ll)
	);

	// Rounding to result steps, ties toward plus infinity, then saturation.
	logic [PREC+1:0]        q_up;
	logic [PREC+1:0]        q_dn;
	logic [PREC+1:0]        l_up;
	logic signed [YW-1:0]   relu_v;
	logic signed [YW-1:0]   ysum;
	logic [DATA_WIDTH-1:0]  y_next;
	logic                   clip_next;

	assign q_up = ({1'b0, lq} + HALF) >> SH;
	assign q_dn = ({1'b0, lq} + HALF - 1'b1) >> SH;
	assign l_up = ({1'b0, ll} + HALF) >> SH;
	assign relu_v = lsd.neg ? '0 : (YW)'(lx);

	always_comb begin
		case (lsd.kind)
			ACT_SIGMOID: ysum = (YW)'(q_up[FRAC_BITS:0]);
			ACT_TANH:    ysum = lsd.neg ? -(YW)'(q_dn[FRAC_BITS:0])
			                            : (YW)'(q_up[FRAC_BITS:0]);
			ACT_RELU:    ysum = relu_v;
			default:     ysum = relu_v + (YW)'(l_up[FRAC_BITS:0]);
		endcase
		if (ysum > YMAX) begin
			y_next    = YMAX[DATA_WIDTH-1:0];
			clip_next = 1'b1;
		end else if (ysum < YMIN) begin
			y_next    = YMIN[DATA_WIDTH-1:0];
			clip_next = 1'b1;
		end else begin
			y_next    = ysum[DATA_WIDTH-1:0];
			clip_next = 1'b0;
		end
	end

	// Output register; the kind rides along for checking only.
	act_kind_t             kind_o_q;
	logic [DATA_WIDTH-1:0] y_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= lv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			y_q          <= y_next;
			m_axis_tuser <= clip_next;
			kind_o_q     <= lsd.kind;
		end
	end
	assign m_axis_tdata = (TDW)'(y_q);

	`include "neural_activation_unit_top_assert.svh"

	`NAU_ASSERT_IMP(a_clip_at_limit, m_axis_tvalid && m_axis_tuser,
		y_q == YMAX[DATA_WIDTH-1:0] || y_q == YMIN[DATA_WIDTH-1:0],
		"clipped result is not at a format limit")
	`NAU_ASSERT_IMP(a_relu_no_clip, m_axis_tvalid && kind_o_q == ACT_RELU,
		!m_axis_tuser, "ReLU result flagged as clipped")
	`NAU_ASSERT_IMP(a_sigmoid_nonneg, m_axis_tvalid && kind_o_q == ACT_SIGMOID,
		!y_q[DATA_WIDTH-1], "sigmoid result is negative")
	`NAU_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready,
		v_s1, "accepted transfer did not enter the pipeline")
endmodule
`default_nettype wire
